@@ design/line_origin_map_lookup_top_assert.svh @@
// ----------------------------------------------------------------------------
// line_origin_map_lookup_top_assert.svh
// Assertion macros shared by the line origin map lookup block.
// ----------------------------------------------------------------------------
`ifndef LINE_ORIGIN_MAP_LOOKUP_TOP_ASSERT_SVH
`define LINE_ORIGIN_MAP_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define LOMAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define LOMAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lomap_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lomap_pkg
// Shared constants, codes and types of the line origin map lookup block.
// ----------------------------------------------------------------------------
package lomap_pkg;

    localparam int MAP_DEPTH    = 64;
    localparam int FILE_ID_BITS = 16;

    localparam int IDX_W      = $clog2(MAP_DEPTH);
    localparam int CNT_W      = $clog2(MAP_DEPTH + 1);
    localparam int LINE_W     = 32;
    localparam int STEP_W     = 16;
    localparam int OUT_FILE_W = 16;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 80;

    typedef enum logic [1:0] {
        MODE_SET    = 2'd0,
        MODE_NEXT   = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_NO_MAP = 2'd2,
        STAT_BEYOND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_FETCH,
        ST_MUL,
        ST_ADD
    } state_t;

    // One mapping record as held in the table memory
    typedef struct packed {
        logic [LINE_W-1:0]       start;
        logic [FILE_ID_BITS-1:0] file;
        logic [LINE_W-1:0]       base;
        logic [STEP_W-1:0]       step;
    } rec_t;

    // Controller to datapath
    typedef struct packed {
        logic    capture;     // latch query, start search
        logic    wr_rec;      // append record
        logic    inc_line;    // advance line counter
        logic    emit;        // load result word with zero mapping
        status_t code;        // status for emit
        logic    probe_rd;    // read record at pos + probe
        logic    probe_skip;  // probe out of range, halve it
        logic    probe_cmp;   // compare read record, halve probe
        logic    fetch_rd;    // read final record at pos
        logic    take_rec;    // latch final record, form offset
        logic    mul;         // step * offset
        logic    emit_map;    // load result word with mapping
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  full;
        logic  empty;
        logic  beyond;
        logic  probe_zero;
        logic  at_ok;
        logic  rec_gt_q;
        logic  out_free;
    } sts_t;

endpackage

@@ design/lomap_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lomap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lomap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/lomap_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lomap_datapath
// Line counter, record table, search pointers, offset multiply and result word.
// ----------------------------------------------------------------------------
module lomap_datapath
    import lomap_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    localparam int REC_BITS = $bits(rec_t);

    // Input word fields
    logic [OUT_FILE_W-1:0] s_file;
    logic [LINE_W-1:0]     s_base;
    logic [STEP_W-1:0]     s_step;
    logic [LINE_W-1:0]     s_query;

    assign s_file  = s_tdata[15:0];
    assign s_base  = s_tdata[47:16];
    assign s_step  = s_tdata[63:48];
    assign s_query = s_tdata[95:64];

    logic [LINE_W-1:0]       line_reg, line_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        probe_reg, probe_next;
    logic [LINE_W-1:0]       q_reg, q_next;
    logic [LINE_W-1:0]       off_reg, off_next;
    logic [FILE_ID_BITS-1:0] file_reg, file_next;
    logic [LINE_W-1:0]       base_reg, base_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [LINE_W-1:0]       prod_reg, prod_next;
    logic                    m_valid_reg, m_valid_next;
    logic [LINE_W-1:0]       m_index_reg, m_index_next;
    logic [OUT_FILE_W-1:0]   m_file_reg, m_file_next;
    logic [LINE_W-1:0]       m_line_reg, m_line_next;
    status_t                 m_stat_reg, m_stat_next;

    logic [CNT_W-1:0]         at;
    logic [CNT_W-1:0]         top_probe;
    logic [STEP_W+LINE_W-1:0] prod_full;
    rec_t                     wr_rec;
    rec_t                     rd_rec;
    logic [REC_BITS-1:0]      rd_bits;
    logic [IDX_W-1:0]         raddr;

    // Largest power of two not above the record count
    always_comb begin
        top_probe = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (count_reg[i]) begin
                top_probe = CNT_W'(1) << i;
            end
        end
    end

    assign at        = CNT_W'(pos_reg) + probe_reg;
    assign raddr     = cmd.fetch_rd ? pos_reg : at[IDX_W-1:0];
    assign rd_rec    = rec_t'(rd_bits);
    assign prod_full = step_reg * off_reg;

    assign wr_rec.start = line_reg;
    assign wr_rec.file  = FILE_ID_BITS'(s_file);
    assign wr_rec.base  = s_base;
    assign wr_rec.step  = s_step;

    // Record table
    lomap_ram #(
        .WIDTH (REC_BITS),
        .DEPTH (MAP_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.wr_rec),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_rec),
        .raddr (raddr),
        .rdata (rd_bits)
    );

    // Status back to the controller
    assign sts.mode       = mode_t'(s_tuser);
    assign sts.full       = (count_reg == CNT_W'(MAP_DEPTH));
    assign sts.empty      = (count_reg == '0);
    assign sts.beyond     = (s_query > line_reg);
    assign sts.probe_zero = (probe_reg == '0);
    assign sts.at_ok      = (at < count_reg);
    assign sts.rec_gt_q   = (rd_rec.start > q_reg);
    assign sts.out_free   = !m_valid_reg || m_tready;

    // Next-state logic
    always_comb begin
        line_next    = line_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        probe_next   = probe_reg;
        q_next       = q_reg;
        off_next     = off_reg;
        file_next    = file_reg;
        base_next    = base_reg;
        step_next    = step_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg;
        m_index_next = m_index_reg;
        m_file_next  = m_file_reg;
        m_line_next  = m_line_reg;
        m_stat_next  = m_stat_reg;

        // counter saturates at its top
        if (cmd.inc_line && (line_reg != '1)) begin
            line_next = line_reg + LINE_W'(1);
        end
        if (cmd.wr_rec) begin
            count_next = count_reg + CNT_W'(1);
        end

        // search pointers
        if (cmd.capture) begin
            q_next     = s_query;
            pos_next   = '0;
            probe_next = top_probe;
        end
        if (cmd.probe_skip) begin
            probe_next = probe_reg >> 1;
        end
        if (cmd.probe_cmp) begin
            if (rd_rec.start <= q_reg) begin
                pos_next = at[IDX_W-1:0];
            end
            probe_next = probe_reg >> 1;
        end

        // translation arithmetic
        if (cmd.take_rec) begin
            off_next  = q_reg - rd_rec.start;
            file_next = rd_rec.file;
            base_next = rd_rec.base;
            step_next = rd_rec.step;
        end
        if (cmd.mul) begin
            prod_next = prod_full[LINE_W-1:0];
        end

        // result word
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_index_next = line_next;
            m_file_next  = '0;
            m_line_next  = '0;
            m_stat_next  = cmd.code;
        end else if (cmd.emit_map) begin
            m_valid_next = 1'b1;
            m_index_next = line_reg;
            m_file_next  = OUT_FILE_W'(file_reg);
            m_line_next  = base_reg + prod_reg;
            m_stat_next  = STAT_OK;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg    <= LINE_W'(1);
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            line_reg    <= line_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        probe_reg   <= probe_next;
        q_reg       <= q_next;
        off_reg     <= off_next;
        file_reg    <= file_next;
        base_reg    <= base_next;
        step_reg    <= step_next;
        prod_reg    <= prod_next;
        m_index_reg <= m_index_next;
        m_file_reg  <= m_file_next;
        m_line_reg  <= m_line_next;
        m_stat_reg  <= m_stat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_line_reg, m_file_reg, m_index_reg};
    assign m_tuser  = m_stat_reg;

endmodule

@@ design/lomap_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lomap_ctrl
// Item dispatch and binary search sequencer of the line origin map lookup.
// ----------------------------------------------------------------------------
module lomap_ctrl
    import lomap_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = STAT_OK;
        s_tready   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free) begin
                    case (sts.mode)
                        MODE_SET: begin
                            cmd.emit = 1'b1;
                            if (sts.full) begin
                                cmd.code = STAT_FULL;
                            end else begin
                                cmd.wr_rec = 1'b1;
                            end
                        end
                        MODE_NEXT: begin
                            cmd.inc_line = 1'b1;
                            cmd.emit     = 1'b1;
                        end
                        MODE_LOOKUP: begin
                            if (sts.beyond) begin
                                cmd.emit = 1'b1;
                                cmd.code = STAT_BEYOND;
                            end else if (sts.empty) begin
                                cmd.emit = 1'b1;
                                cmd.code = STAT_NO_MAP;
                            end else begin
                                cmd.capture = 1'b1;
                                state_next  = ST_PROBE;
                            end
                        end
                        default: begin
                            cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            // one halving step; reads only below the record count
            ST_PROBE: begin
                if (sts.probe_zero) begin
                    cmd.fetch_rd = 1'b1;
                    state_next   = ST_FETCH;
                end else if (sts.at_ok) begin
                    cmd.probe_rd = 1'b1;
                    state_next   = ST_CMP;
                end else begin
                    cmd.probe_skip = 1'b1;
                end
            end
            ST_CMP: begin
                cmd.probe_cmp = 1'b1;
                state_next    = ST_PROBE;
            end
            // only the first record can start above the query here
            ST_FETCH: begin
                if (sts.rec_gt_q) begin
                    cmd.emit   = 1'b1;
                    cmd.code   = STAT_NO_MAP;
                    state_next = ST_IDLE;
                end else begin
                    cmd.take_rec = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.emit_map = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/line_origin_map_lookup_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_origin_map_lookup_top
// Virtual line counter with a table of line origin records and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser carries the mode (set,
//   next, lookup). Each input word yields exactly one result word on
//   m_tvalid/m_tready, with the status code in m_tuser.
//   Set, next, unused mode, a query beyond the counter and a lookup on an
//   empty table answer in the cycle after acceptance.
//   A lookup walks the table with a power-of-two binary search through the
//   record memory's single read port: each probe that lands inside the
//   table is read and then compared, each probe that lands beyond it is
//   skipped, and then come a record fetch, a multiply and an add.
//   One word is in flight at a time; s_tready is high only when the block is
//   idle and the result register is empty or being drained this cycle. A
//   stalled receiver holds the result word and blocks further input.
//   Reset sets the line counter to 1 and empties the table; memory contents
//   need no clearing, as only entries below the record count are read.
// ----------------------------------------------------------------------------
`include "line_origin_map_lookup_top_assert.svh"

module line_origin_map_lookup_top
    import lomap_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: file_id[15:0], base_line[47:16], line_step[63:48],
    //          query_index[95:64]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: mode[1:0]
    input  logic [1:0]           s_tuser,
    // m_tdata: current_index[31:0], mapped_file_id[47:32], mapped_line[79:48]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]           m_tuser
);

    cmd_t cmd;
    sts_t sts;

    lomap_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lomap_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    // A pending result word is never overwritten by a new input word
    `LOMAP_ASSERT_NOW(a_no_overrun, aclk, aresetn, s_tvalid && s_tready, !m_tvalid || m_tready, "input accepted over a pending result")

    // Set and next answer in the following cycle
    `LOMAP_ASSERT_NEXT(a_quick_resp, aclk, aresetn, s_tvalid && s_tready && (s_tuser == MODE_SET || s_tuser == MODE_NEXT), m_tvalid, "set or next item gave no result")

    // Any non-ok status carries zero file and line fields
    `LOMAP_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && (m_tuser != STAT_OK), m_tdata[79:32] == '0, "mapping fields set on error status")

endmodule
